// ===== rtl/mbpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mbpm_pkg;

   localparam int BLOCK_LIMIT_DEF = 4096;
   localparam int WORD_W          = 64;
   localparam int BIT_W           = 6;
   localparam int CNT_W           = 13;
   localparam int SHIFT_W         = 6;
   localparam int ADDR_W          = 64;
   localparam int CSR_IDX_W       = 3;

   localparam logic [SHIFT_W-1:0] SHIFT_MAX = 6'd40;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET  = 6'd21;
   localparam logic [CNT_W-1:0]   REGION_RESET = 13'd4096;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SHIFT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REQUESTED   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_USABLE = 3'd4;

   // request types
   localparam logic [15:0] REQ_PLUG       = 16'd0;
   localparam logic [15:0] REQ_UNPLUG     = 16'd1;
   localparam logic [15:0] REQ_UNPLUG_ALL = 16'd2;
   localparam logic [15:0] REQ_STATE      = 16'd3;

   // response status
   localparam logic [1:0] STATUS_ACK   = 2'd0;
   localparam logic [1:0] STATUS_NACK  = 2'd1;
   localparam logic [1:0] STATUS_BUSY  = 2'd2;
   localparam logic [1:0] STATUS_ERROR = 2'd3;

   localparam logic [1:0] PSTAT_OK   = 2'd0;
   localparam logic [1:0] PSTAT_BUSY = 2'd1;

   localparam logic [1:0] RANGE_UNPLUGGED = 2'd0;
   localparam logic [1:0] RANGE_PLUGGED   = 2'd1;
   localparam logic [1:0] RANGE_MIXED     = 2'd2;

   function automatic logic [1:0] platform_answer(input logic [1:0] pstat);
      logic [1:0] r;
      r = STATUS_ERROR;
      if (pstat == PSTAT_OK) begin
         r = STATUS_ACK;
      end else if (pstat == PSTAT_BUSY) begin
         r = STATUS_BUSY;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/mbpm_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface mbpm_req_if import mbpm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [15:0]       req_type;
   logic [ADDR_W-1:0] req_address;
   logic [15:0]       req_block_count;
   logic [1:0]        platform_status;

   modport source (output valid, req_type, req_address, req_block_count, platform_status,
                   input ready);
   modport sink (input valid, req_type, req_address, req_block_count, platform_status,
                 output ready);
endinterface

interface mbpm_rsp_if import mbpm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        resp_status;
   logic [1:0]        range_state;
   logic              platform_called;
   logic [ADDR_W-1:0] platform_address;
   logic [CNT_W-1:0]  platform_blocks;
   logic              platform_plug;
   logic [CNT_W-1:0]  plugged_total;
   logic [CNT_W-1:0]  usable_total;

   modport source (output valid, resp_status, range_state, platform_called, platform_address,
                   platform_blocks, platform_plug, plugged_total, usable_total,
                   input ready);
   modport sink (input valid, resp_status, range_state, platform_called, platform_address,
                 platform_blocks, platform_plug, plugged_total, usable_total,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/mbpm_word_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mbpm_word_eval import mbpm_pkg::*; #(
   parameter int WI = 6
) (
   input  wire logic [WORD_W-1:0] word_in,
   input  wire logic [WI-1:0]     word_idx,
   input  wire logic [WI-1:0]     first_word,
   input  wire logic [WI-1:0]     last_word,
   input  wire logic [BIT_W-1:0]  lo_bit,
   input  wire logic [BIT_W-1:0]  hi_bit,
   input  wire logic              plug,
   output logic [BIT_W:0]         hit_count,
   output logic                   clash,
   output logic [WORD_W-1:0]      word_out
);

   logic [BIT_W-1:0]  lo;
   logic [BIT_W-1:0]  hi;
   logic [WORD_W-1:0] mask;
   logic [WORD_W-1:0] hits;

   always_comb begin
      lo = (word_idx == first_word) ? lo_bit : '0;
      hi = (word_idx == last_word) ? hi_bit : BIT_W'(WORD_W - 1);
      mask = ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi));
      hits = word_in & mask;
      hit_count = '0;
      for (int j = 0; j < WORD_W; j++) begin
         hit_count = hit_count + (BIT_W + 1)'(hits[j]);
      end
      clash = plug ? (|hits) : (|(~word_in & mask));
      word_out = plug ? (word_in | mask) : (word_in & ~mask);
   end

endmodule
`default_nettype wire

// ===== rtl/memory_block_plug_manager_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Hot-plug memory block manager.
// req_ch carries one request (type, guest address, block count and the
// platform mapping outcome); rsp_ch returns one response per request, in
// order. csr_we/csr_index/csr_data write the configuration registers; the user
// must do so only while the block is idle, which the block does not enforce.
// The plugged bitmap lives in a 64-bit wide synchronous RAM of BLOCK_LIMIT/64
// words, rounded up. After acceptance a request passes the range checks,
// scans the bitmap words it touches, decides and, for a successful plug or
// unplug, writes those words back; then it loads the response register. A
// failed range check, or an unplug-all that issues nothing or is refused, goes
// straight to loading the response. A successful unplug-all instead sweeps
// the whole RAM before its response is loaded. Once it is loaded the block
// returns to idle and takes the next request. After reset the same sweep
// clears the bitmap; req_ch.ready stays low during it.
// The response sits in an output register; a new request is accepted while
// it waits. When the receiver stalls, a finished request holds until the
// register frees up, and no further request is taken meanwhile.
module memory_block_plug_manager_unit import mbpm_pkg::*; #(
   parameter int BLOCK_LIMIT = BLOCK_LIMIT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   mbpm_req_if.sink                  req_ch,
   mbpm_rsp_if.source                rsp_ch,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ADDR_W-1:0]    csr_data
);

   localparam int WORDS = (BLOCK_LIMIT + WORD_W - 1) / WORD_W;
   localparam int WI    = (WORDS > 1) ? $clog2(WORDS) : 1;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_RANGE  = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_DECIDE = 3'd5;
   localparam logic [2:0] S_WRITE  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   function automatic logic [WI-1:0] word_of(input logic [CNT_W-1:0] b);
      logic [31:0] t;
      t = 32'(b) >> BIT_W;
      return t[WI-1:0];
   endfunction

   // configuration
   logic [SHIFT_W-1:0] shift_ff;
   logic [ADDR_W-1:0]  base_ff;
   logic [CNT_W-1:0]   region_ff;
   logic [CNT_W-1:0]   requested_ff;

   // block state
   logic [CNT_W-1:0]   plugged_ff;
   logic [CNT_W-1:0]   usable_ff;

   logic [2:0]         state_ff, state_in;

   // latched request
   logic [15:0]        q_type_ff;
   logic [ADDR_W-1:0]  q_addr_ff;
   logic [15:0]        q_count_ff;
   logic [1:0]         q_pstat_ff;

   // range check pipeline
   logic [ADDR_W-1:0]  off_ff, ubytes_ff, bytes_ff;
   logic               pre_ok_ff;

   logic [CNT_W-1:0]   first_ff, cnt_ff, lastb_ff;
   logic [WI-1:0]      first_w_ff, last_w_ff;

   // scan and write-back pipe
   logic [WI-1:0]      rd_idx_ff, p_idx_ff, clr_idx_ff;
   logic               issue_ff, p_valid_ff;
   logic [WORD_W-1:0]  rdata_ff;
   logic [CNT_W-1:0]   ones_ff;
   logic               clash_ff;
   logic               clear_then_done_ff;

   // result being built
   logic [1:0]         res_status_ff, res_rstate_ff;
   logic               res_called_ff, res_plug_ff;
   logic [ADDR_W-1:0]  res_paddr_ff;
   logic [CNT_W-1:0]   res_pblocks_ff;

   // response register
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff, rsp_rstate_ff;
   logic               rsp_called_ff, rsp_plug_ff;
   logic [ADDR_W-1:0]  rsp_paddr_ff;
   logic [CNT_W-1:0]   rsp_pblocks_ff, rsp_plugged_ff, rsp_usable_ff;

   logic [WORD_W-1:0]  map_mem [WORDS];

   logic [SHIFT_W-1:0] eff_shift;
   logic [CNT_W-1:0]   eff_region, lim, req_cfg_v, first_in;
   logic [ADDR_W-1:0]  shift_mask;
   logic               range_ok;
   logic               in_acc, rsp_free, is_plug;
   logic [BIT_W:0]     hit_count;
   logic               word_clash;
   logic [WORD_W-1:0]  word_new;
   logic               mem_we;
   logic [WI-1:0]      mem_waddr;
   logic [WORD_W-1:0]  mem_wdata;
   logic [1:0]         pf_answer;

   always_comb begin
      eff_shift  = (shift_ff > SHIFT_MAX) ? SHIFT_MAX : shift_ff;
      eff_region = (32'(region_ff) > BLOCK_LIMIT) ? CNT_W'(BLOCK_LIMIT) : region_ff;
      lim        = (usable_ff < eff_region) ? usable_ff : eff_region;
      req_cfg_v  = (csr_data[CNT_W-1:0] > eff_region) ? eff_region : csr_data[CNT_W-1:0];
      shift_mask = ~({ADDR_W{1'b1}} << eff_shift);
      range_ok   = pre_ok_ff && (off_ff <= ubytes_ff) && (bytes_ff <= ubytes_ff - off_ff);
      first_in   = CNT_W'(off_ff >> eff_shift);
      in_acc     = req_ch.valid && req_ch.ready;
      rsp_free   = !rsp_valid_ff || rsp_ch.ready;
      is_plug    = (q_type_ff == REQ_PLUG);
      pf_answer  = platform_answer(q_pstat_ff);
   end

   mbpm_word_eval #(.WI(WI)) u_word_eval (
      .word_in    (rdata_ff),
      .word_idx   (p_idx_ff),
      .first_word (first_w_ff),
      .last_word  (last_w_ff),
      .lo_bit     (first_ff[BIT_W-1:0]),
      .hi_bit     (lastb_ff[BIT_W-1:0]),
      .plug       (is_plug),
      .hit_count  (hit_count),
      .clash      (word_clash),
      .word_out   (word_new)
   );

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_idx_ff;
      mem_wdata = '0;
      if (state_ff == S_CLEAR) begin
         mem_we = 1'b1;
      end else if (state_ff == S_WRITE && p_valid_ff) begin
         mem_we    = 1'b1;
         mem_waddr = p_idx_ff;
         mem_wdata = word_new;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= map_mem[rd_idx_ff];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:  if (clr_idx_ff == WI'(WORDS - 1)) begin
                      state_in = clear_then_done_ff ? S_DONE : S_IDLE;
                   end
         S_IDLE:   if (in_acc) begin
                      state_in = S_RANGE;
                   end
         S_RANGE:  begin
                      if (q_type_ff != REQ_UNPLUG_ALL) begin
                         state_in = S_CHECK;
                      end else if (plugged_ff != '0 && pf_answer == STATUS_ACK) begin
                         state_in = S_CLEAR;
                      end else begin
                         state_in = S_DONE;
                      end
                   end
         S_CHECK:  state_in = range_ok ? S_SCAN : S_DONE;
         S_SCAN:   if (p_valid_ff && p_idx_ff == last_w_ff) begin
                      state_in = S_DECIDE;
                   end
         S_DECIDE: begin
                      state_in = S_DONE;
                      if (q_type_ff != REQ_STATE && !clash_ff && pf_answer == STATUS_ACK &&
                          !(is_plug && (plugged_ff > requested_ff ||
                                        cnt_ff > requested_ff - plugged_ff))) begin
                         state_in = S_WRITE;
                      end
                   end
         S_WRITE:  if (p_valid_ff && p_idx_ff == last_w_ff) begin
                      state_in = S_DONE;
                   end
         S_DONE:   if (rsp_free) begin
                      state_in = S_IDLE;
                   end
         default:  state_in = S_IDLE;
      endcase
   end

   assign req_ch.ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_CLEAR;
         clr_idx_ff         <= '0;
         clear_then_done_ff <= 1'b0;
         issue_ff           <= 1'b0;
         p_valid_ff         <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         shift_ff           <= SHIFT_RESET;
         base_ff            <= '0;
         region_ff          <= REGION_RESET;
         requested_ff       <= '0;
         plugged_ff         <= '0;
         usable_ff          <= '0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            unique case (csr_index)
               CSR_BLOCK_SHIFT: shift_ff <= csr_data[SHIFT_W-1:0];
               CSR_BASE:        base_ff <= csr_data;
               CSR_REGION:      region_ff <= csr_data[CNT_W-1:0];
               CSR_REQUESTED:   begin
                                   requested_ff <= req_cfg_v;
                                   if (usable_ff < req_cfg_v) begin
                                      usable_ff <= req_cfg_v;
                                   end
                                end
               default:         ;
            endcase
         end

         if (state_ff == S_CLEAR) begin
            clr_idx_ff <= (clr_idx_ff == WI'(WORDS - 1)) ? '0 : clr_idx_ff + WI'(1);
         end

         // read pipe shared by scan and write-back
         if (issue_ff) begin
            p_valid_ff <= 1'b1;
            p_idx_ff   <= rd_idx_ff;
            if (rd_idx_ff == last_w_ff) begin
               issue_ff <= 1'b0;
            end else begin
               rd_idx_ff <= rd_idx_ff + WI'(1);
            end
         end else begin
            p_valid_ff <= 1'b0;
         end

         // in the done state the load below decides the valid bit
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (in_acc) begin
                  q_type_ff      <= req_ch.req_type;
                  q_addr_ff      <= req_ch.req_address;
                  q_count_ff     <= req_ch.req_block_count;
                  q_pstat_ff     <= req_ch.platform_status;
                  res_status_ff  <= STATUS_ERROR;
                  res_rstate_ff  <= RANGE_UNPLUGGED;
                  res_called_ff  <= 1'b0;
                  res_plug_ff    <= 1'b0;
                  res_paddr_ff   <= '0;
                  res_pblocks_ff <= '0;
               end
            end
            S_RANGE: begin
               pre_ok_ff <= (q_type_ff <= REQ_STATE) && (q_count_ff != '0) &&
                            (q_addr_ff >= base_ff) && ((q_addr_ff & shift_mask) == '0);
               off_ff    <= q_addr_ff - base_ff;
               ubytes_ff <= ADDR_W'(lim) << eff_shift;
               bytes_ff  <= ADDR_W'(q_count_ff) << eff_shift;
               if (q_type_ff == REQ_UNPLUG_ALL) begin
                  if (plugged_ff == '0) begin
                     usable_ff     <= requested_ff;
                     res_status_ff <= STATUS_ACK;
                  end else begin
                     res_called_ff  <= 1'b1;
                     res_paddr_ff   <= base_ff;
                     res_pblocks_ff <= eff_region;
                     res_status_ff  <= pf_answer;
                     if (pf_answer == STATUS_ACK) begin
                        plugged_ff         <= '0;
                        usable_ff          <= requested_ff;
                        clear_then_done_ff <= 1'b1;
                     end
                  end
               end
            end
            S_CHECK: begin
               first_ff   <= first_in;
               cnt_ff     <= q_count_ff[CNT_W-1:0];
               lastb_ff   <= first_in + q_count_ff[CNT_W-1:0] - CNT_W'(1);
               first_w_ff <= word_of(first_in);
               last_w_ff  <= word_of(first_in + q_count_ff[CNT_W-1:0] - CNT_W'(1));
               rd_idx_ff  <= word_of(first_in);
               ones_ff    <= '0;
               clash_ff   <= 1'b0;
               if (range_ok) begin
                  issue_ff <= 1'b1;
               end
            end
            S_SCAN: begin
               if (p_valid_ff) begin
                  ones_ff  <= ones_ff + CNT_W'(hit_count);
                  clash_ff <= clash_ff | word_clash;
               end
            end
            S_DECIDE: begin
               if (q_type_ff == REQ_STATE) begin
                  res_status_ff <= STATUS_ACK;
                  res_rstate_ff <= (ones_ff == '0) ? RANGE_UNPLUGGED :
                                   ((ones_ff == cnt_ff) ? RANGE_PLUGGED : RANGE_MIXED);
               end else if (clash_ff) begin
                  res_status_ff <= STATUS_ERROR;
               end else if (is_plug && (plugged_ff > requested_ff ||
                                        cnt_ff > requested_ff - plugged_ff)) begin
                  res_status_ff <= STATUS_NACK;
               end else begin
                  res_called_ff  <= 1'b1;
                  res_plug_ff    <= is_plug;
                  res_pblocks_ff <= cnt_ff;
                  res_paddr_ff   <= base_ff + (ADDR_W'(first_ff) << eff_shift);
                  res_status_ff  <= pf_answer;
                  if (pf_answer == STATUS_ACK) begin
                     plugged_ff <= is_plug ? plugged_ff + cnt_ff : plugged_ff - cnt_ff;
                     rd_idx_ff  <= first_w_ff;
                     issue_ff   <= 1'b1;
                  end
               end
            end
            S_DONE: begin
               clear_then_done_ff <= 1'b0;
               if (rsp_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= res_status_ff;
                  rsp_rstate_ff  <= res_rstate_ff;
                  rsp_called_ff  <= res_called_ff;
                  rsp_plug_ff    <= res_plug_ff;
                  rsp_paddr_ff   <= res_paddr_ff;
                  rsp_pblocks_ff <= res_pblocks_ff;
                  rsp_plugged_ff <= plugged_ff;
                  rsp_usable_ff  <= usable_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.resp_status      = rsp_status_ff;
   assign rsp_ch.range_state      = rsp_rstate_ff;
   assign rsp_ch.platform_called  = rsp_called_ff;
   assign rsp_ch.platform_address = rsp_paddr_ff;
   assign rsp_ch.platform_blocks  = rsp_pblocks_ff;
   assign rsp_ch.platform_plug    = rsp_plug_ff;
   assign rsp_ch.plugged_total    = rsp_plugged_ff;
   assign rsp_ch.usable_total     = rsp_usable_ff;

   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ch.ready)
      else $error("request taken during bitmap clear");

   a_pipe_only_in_walk: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> (state_ff == S_SCAN || state_ff == S_WRITE))
      else $error("bitmap read pipe active outside scan or write-back");

   a_plugged_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(plugged_ff) <= BLOCK_LIMIT)
      else $error("plugged count beyond bitmap size");

   a_rsp_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response loaded outside completion");

endmodule
`default_nettype wire

// ===== tb/memory_block_plug_manager_checker.sv =====
`timescale 1ns / 1ps
module memory_block_plug_manager_checker import mbpm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   mbpm_req_if                  req_ch,
   mbpm_rsp_if                  rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_data,
   output int                   fail_count,
   output int                   pending,
   output int                   acked_count,
   output int                   request_count
);
   typedef struct packed {
      logic [1:0]        status;
      logic [1:0]        range_st;
      logic              called;
      logic [ADDR_W-1:0] paddr;
      logic [CNT_W-1:0]  pblocks;
      logic              pplug;
      logic [CNT_W-1:0]  plugged;
      logic [CNT_W-1:0]  usable;
   } answer_type;

   localparam int NBLK = BLOCK_LIMIT_DEF;

   answer_type        answer_q[$];
   logic [NBLK-1:0]   plugged_map;
   logic [CNT_W-1:0]  plugged_cnt;
   logic [CNT_W-1:0]  usable_cnt;
   logic [SHIFT_W-1:0] shift_reg;
   logic [ADDR_W-1:0] base_reg;
   logic [CNT_W-1:0]  region_reg;
   logic [CNT_W-1:0]  requested_reg;
   logic [CNT_W-1:0]  init_usable_reg;

   function automatic logic [CNT_W-1:0] region_eff();
      return (region_reg > NBLK) ? CNT_W'(NBLK) : region_reg;
   endfunction

   function automatic logic [1:0] map_outcome(input logic [1:0] ps);
      if (ps == PSTAT_OK) return STATUS_ACK;
      if (ps == PSTAT_BUSY) return STATUS_BUSY;
      return STATUS_ERROR;
   endfunction

   task automatic apply_setting(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] d);
      logic [CNT_W-1:0] v;
      v = d[CNT_W-1:0];
      case (idx)
         CSR_BLOCK_SHIFT: shift_reg = d[SHIFT_W-1:0];
         CSR_BASE:        base_reg = d;
         CSR_REGION:      region_reg = v;
         CSR_REQUESTED: begin
            if (v > region_eff()) v = region_eff();
            requested_reg = v;
            if (usable_cnt < v) usable_cnt = v;
         end
         CSR_INIT_USABLE: init_usable_reg = v;
         default: ;
      endcase
   endtask

   task automatic handle_request(input logic [15:0] kind, input logic [ADDR_W-1:0] addr,
                                 input logic [15:0] cnt, input logic [1:0] ps,
                                 output answer_type a);
      logic [5:0]        s;
      logic [CNT_W-1:0]  lim;
      logic [ADDR_W-1:0] ubytes, nbytes, off;
      int                first, hits;
      logic              ok, tgt, clash;
      a = '0;
      a.status = STATUS_ERROR;
      s = (shift_reg > SHIFT_MAX) ? SHIFT_MAX : shift_reg;
      first = 0;
      if (kind == REQ_UNPLUG_ALL) begin
         if (plugged_cnt == 0) begin
            usable_cnt = requested_reg;
            a.status = STATUS_ACK;
         end else begin
            a.called = 1'b1;
            a.paddr = base_reg;
            a.pblocks = region_eff();
            a.status = map_outcome(ps);
            if (a.status == STATUS_ACK) begin
               plugged_map = '0;
               plugged_cnt = '0;
               usable_cnt = requested_reg;
            end
         end
      end else begin
         ok = 1'b0;
         lim = (usable_cnt < region_eff()) ? usable_cnt : region_eff();
         if (kind <= REQ_STATE && cnt != 0 && addr >= base_reg &&
             (addr & ((64'd1 << s) - 64'd1)) == 64'd0) begin
            ubytes = 64'(lim) << s;
            nbytes = 64'(cnt) << s;
            off = addr - base_reg;
            if (off <= ubytes && nbytes <= ubytes - off) begin
               first = int'(off >> s);
               ok = 1'b1;
            end
         end
         if (!ok) begin
            a.status = STATUS_ERROR;
         end else if (kind == REQ_STATE) begin
            hits = 0;
            for (int i = 0; i < cnt; i++) hits += plugged_map[first + i];
            a.range_st = (hits == 0) ? RANGE_UNPLUGGED :
                         (hits == cnt) ? RANGE_PLUGGED : RANGE_MIXED;
            a.status = STATUS_ACK;
         end else begin
            tgt = (kind == REQ_PLUG);
            clash = 1'b0;
            for (int i = 0; i < cnt; i++)
               if (plugged_map[first + i] == tgt) clash = 1'b1;
            if (clash) begin
               a.status = STATUS_ERROR;
            end else if (tgt && (plugged_cnt > requested_reg ||
                                 cnt > requested_reg - plugged_cnt)) begin
               a.status = STATUS_NACK;
            end else begin
               a.called = 1'b1;
               a.pplug = tgt;
               a.pblocks = cnt[CNT_W-1:0];
               a.paddr = base_reg + (64'(first) << s);
               a.status = map_outcome(ps);
               if (a.status == STATUS_ACK) begin
                  for (int i = 0; i < cnt; i++) plugged_map[first + i] = tgt;
                  if (tgt) plugged_cnt = plugged_cnt + cnt[CNT_W-1:0];
                  else plugged_cnt = plugged_cnt - cnt[CNT_W-1:0];
               end
            end
         end
      end
      a.plugged = plugged_cnt;
      a.usable = usable_cnt;
   endtask

   function automatic void compare(input string name, input logic [63:0] exp_v,
                                   input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      answer_type a;
      if (reset) begin
         answer_q.delete();
         plugged_map = '0;
         plugged_cnt = '0;
         shift_reg = SHIFT_RESET;
         base_reg = '0;
         region_reg = REGION_RESET;
         requested_reg = '0;
         init_usable_reg = '0;
         usable_cnt = '0;
         fail_count = 0;
         acked_count = 0;
         request_count = 0;
      end else begin
         if (csr_we) apply_setting(csr_index, csr_data);
         // response first, so a request taken on the same edge cannot match it
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (answer_q.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               a = answer_q.pop_front();
               compare("resp_status", a.status, rsp_ch.resp_status);
               compare("range_state", a.range_st, rsp_ch.range_state);
               compare("platform_called", a.called, rsp_ch.platform_called);
               compare("platform_address", a.paddr, rsp_ch.platform_address);
               compare("platform_blocks", a.pblocks, rsp_ch.platform_blocks);
               compare("platform_plug", a.pplug, rsp_ch.platform_plug);
               compare("plugged_total", a.plugged, rsp_ch.plugged_total);
               compare("usable_total", a.usable, rsp_ch.usable_total);
               if (a.status == STATUS_ACK) acked_count++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            handle_request(req_ch.req_type, req_ch.req_address, req_ch.req_block_count,
                           req_ch.platform_status, a);
            answer_q.push_back(a);
            request_count++;
         end
      end
      pending = answer_q.size();
   end

endmodule

// ===== tb/memory_block_plug_manager_unit_test.sv =====
`timescale 1ns / 1ps
module memory_block_plug_manager_unit_test;
   import mbpm_pkg::*;

   localparam logic [1:0] PSTAT_FAIL = 2'd2;
   localparam logic [1:0] PSTAT_ODD  = 2'd3;
   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE      = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BLOCK_SHIFT;
   logic [ADDR_W-1:0]    csr_data = '0;
   int fail_count, pending, acked_count, request_count;
   int burst_left = 0;
   int quiet_cycles = 0;
   int settings_run = 0;
   logic stimulus_done = 1'b0;

   logic [5:0]        cur_shift;
   logic [ADDR_W-1:0] cur_base;
   int                cur_region;

   mbpm_req_if req_if ();
   mbpm_rsp_if rsp_if ();

   memory_block_plug_manager_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if.sink),
      .rsp_ch    (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   memory_block_plug_manager_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_if),
      .rsp_ch        (rsp_if),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .acked_count   (acked_count),
      .request_count (request_count)
   );

   always #1 clock = ~clock;

   initial begin
      req_if.valid = 1'b0;
      req_if.req_type = '0;
      req_if.req_address = '0;
      req_if.req_block_count = '0;
      req_if.platform_status = '0;
      rsp_if.ready = 1'b0;
   end

   // request sender: bursts of random length, random gaps between them
   task automatic offer(input logic [15:0] kind, input logic [ADDR_W-1:0] addr,
                        input logic [15:0] cnt, input logic [1:0] ps);
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
      end
      req_if.valid <= 1'b1;
      req_if.req_type <= kind;
      req_if.req_address <= addr;
      req_if.req_block_count <= cnt;
      req_if.platform_status <= ps;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      burst_left--;
   endtask

   function automatic logic [ADDR_W-1:0] blk_addr(input int blk);
      logic [5:0] s;
      s = (cur_shift > SHIFT_MAX) ? SHIFT_MAX : cur_shift;
      return cur_base + (64'(blk) << s);
   endfunction

   task automatic drain();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic configure(input logic [5:0] sh, input logic [ADDR_W-1:0] base,
                            input int region, input int requested);
      logic [ADDR_W-1:0] vals [5];
      vals[0] = 64'(sh);
      vals[1] = base;
      vals[2] = 64'(region);
      vals[3] = 64'(requested);
      vals[4] = 64'($urandom_range(0, 8191));
      drain();
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_data <= vals[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
      cur_shift = sh;
      cur_base = base;
      cur_region = (region > BLOCK_LIMIT_DEF) ? BLOCK_LIMIT_DEF : region;
      settings_run++;
   endtask

   task automatic random_requests(input int n, input int max_cnt);
      logic [15:0]       kind;
      logic [ADDR_W-1:0] addr;
      logic [15:0]       cnt;
      logic [1:0]        ps;
      int                r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         ps = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : PSTAT_OK;
         if (r < 85) begin
            r = $urandom_range(0, 99);
            kind = (r < 38) ? REQ_PLUG : (r < 70) ? REQ_UNPLUG :
                   (r < 96) ? REQ_STATE : REQ_UNPLUG_ALL;
            cnt = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, max_cnt))
                                              : 16'($urandom_range(1, 4));
            addr = blk_addr($urandom_range(0, cur_region + 1));
         end else begin
            kind = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(0, 4));
            addr = {$urandom, $urandom};
            cnt = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535)) : 16'd0;
            if ($urandom_range(0, 1) == 0) addr = blk_addr($urandom_range(0, cur_region)) + 1;
         end
         offer(kind, addr, cnt, ps);
      end
   endtask

   // receiver: random stall pattern, stretches of always ready, at least one long hold-off
   initial begin
      int mode, hold_done;
      hold_done = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 9);
         if (mode == 0 || (hold_done == 0 && request_count > 40)) begin
            hold_done++;
            rsp_if.ready <= 1'b0;
            repeat (400) @(negedge clock);
         end else begin
            repeat ($urandom_range(20, 200)) begin
               rsp_if.ready <= (mode < 4) ? 1'b1 : ($urandom_range(0, mode) < 3);
               @(negedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [ADDR_W-1:0] b;
      cur_shift = SHIFT_RESET;
      cur_base = '0;
      cur_region = BLOCK_LIMIT_DEF;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: nothing usable yet
      offer(REQ_PLUG, 64'd0, 16'd1, PSTAT_OK);
      offer(REQ_UNPLUG_ALL, 64'd0, 16'd0, PSTAT_OK);
      offer(16'hFFFF, 64'd0, 16'd1, PSTAT_OK);
      offer(REQ_STATE, 64'd0, 16'd1, PSTAT_OK);

      configure(6'd12, 64'h1000_0000, 64, 48);
      b = cur_base;
      offer(REQ_PLUG, b, 16'd8, PSTAT_OK);
      offer(REQ_PLUG, blk_addr(4), 16'd2, PSTAT_OK);
      offer(REQ_STATE, b, 16'd8, PSTAT_OK);
      offer(REQ_STATE, b, 16'd16, PSTAT_OK);
      offer(REQ_STATE, blk_addr(32), 16'd4, PSTAT_OK);
      offer(REQ_PLUG, blk_addr(8), 16'd41, PSTAT_OK);
      offer(REQ_PLUG, blk_addr(8), 16'd1, PSTAT_BUSY);
      offer(REQ_PLUG, blk_addr(8), 16'd1, PSTAT_FAIL);
      offer(REQ_PLUG, blk_addr(8), 16'd1, PSTAT_ODD);
      offer(REQ_PLUG, b + 1, 16'd1, PSTAT_OK);
      offer(REQ_PLUG, b - 64'h1000, 16'd1, PSTAT_OK);
      offer(REQ_PLUG, blk_addr(9), 16'd0, PSTAT_OK);
      offer(REQ_PLUG, blk_addr(40), 16'd9, PSTAT_OK);
      offer(REQ_UNPLUG, b, 16'd4, PSTAT_OK);
      offer(REQ_UNPLUG, b, 16'd2, PSTAT_OK);
      offer(REQ_UNPLUG_ALL, 64'd0, 16'd0, PSTAT_BUSY);
      offer(REQ_UNPLUG_ALL, 64'd0, 16'd0, PSTAT_OK);
      offer(REQ_STATE, b, 16'hFFFF, PSTAT_OK);
      offer(REQ_STATE, 64'hFFFF_FFFF_FFFF_FFFF, 16'd1, PSTAT_OK);
      random_requests(400, 24);

      configure(6'd0, 64'hFFFF_FFFF_FFFF_F000, 4096, 4096);
      random_requests(300, 64);
      configure(6'd40, 64'hFFF0_0000_0000_0000, 8191, 100);
      random_requests(300, 16);
      configure(6'd63, 64'd0, 1, 1);
      random_requests(200, 2);
      configure(6'd6, 64'h40, 0, 0);
      random_requests(100, 4);
      configure(6'd21, 64'd0, 200, 8191);
      random_requests(600, 200);

      drain();
      $display("covered %0d requests over %0d register settings, %0d acknowledged",
               request_count, settings_run, acked_count);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
